// ===== src/dsrc_pkg.sv =====
package dsrc_pkg;

  // Default sizes
  localparam int CHANNELS_DEF   = 8;
  localparam int FIFO_DEPTH_DEF = 16;

  // Field and register widths
  localparam int DEB_W        = 8;
  localparam int INTERVAL_W   = 10;
  localparam int SWCNT_W      = 4;
  localparam int MASK_W       = 8;
  localparam int CFG_W        = 10;
  localparam int CFG_IDX_W    = 3;
  localparam int REMOTE_IDX_W = 4;
  localparam int IDX_W        = 5;
  localparam int DROP_W       = 4;
  localparam int LEVEL_W      = 5;
  localparam int IN_W         = 16;
  localparam int OUT_W        = 32;

  // Input beat layout
  localparam int IN_RAW_LSB = 0;
  localparam int IN_RVALID  = 8;
  localparam int IN_RIDX_LSB = 9;
  localparam int IN_RON     = 13;

  // Output beat layout
  localparam int OUT_DRIVE_LSB = 0;
  localparam int OUT_MARK_LSB  = 8;
  localparam int OUT_APPLIED   = 16;
  localparam int OUT_IGNORED   = 17;
  localparam int OUT_DROP_LSB  = 18;
  localparam int OUT_LEVEL_LSB = 22;

  // Register reset values
  localparam logic [DEB_W-1:0]      DEBOUNCE_RST = 8'd30;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 10'd100;
  localparam logic [SWCNT_W-1:0]    SWCNT_RST    = 4'd8;
  localparam logic [MASK_W-1:0]     ENABLE_RST   = 8'hFF;
  localparam logic [MASK_W-1:0]     ACTLOW_RST   = 8'hFF;
  localparam logic [MASK_W-1:0]     MOMENT_RST   = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE  = 3'd0,
    REG_INTERVAL  = 3'd1,
    REG_SWCOUNT   = 3'd2,
    REG_ENABLE    = 3'd3,
    REG_ACTLOW    = 3'd4,
    REG_MOMENTARY = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic en;
    logic low_true;
    logic momentary;
  } lane_cfg_t;

  typedef struct packed {
    logic offer;
    logic on;
  } lane_req_t;

  typedef struct packed {
    logic                    valid;
    logic [REMOTE_IDX_W-1:0] index;
    logic                    on;
  } remote_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             on;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             on;
  } apply_t;

  typedef struct packed {
    logic               ignored;
    logic [DROP_W-1:0]  dropped;
    logic [LEVEL_W-1:0] level;
  } queue_status_t;

endpackage

// ===== src/dsrc_lane.sv =====
module dsrc_lane
  import dsrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  lane_cfg_t        cfg,
  input  logic [DEB_W-1:0] debounce_ticks,
  input  logic             raw,
  input  logic             relay,
  output lane_req_t        req,
  output logic             mark
);

  logic             last_raw, last_raw_next;
  logic             stable_level, stable_level_next;
  logic             last_active, last_active_next;
  logic [DEB_W-1:0] since_change, since_change_next;
  logic             override_mark, override_mark_next;
  logic             act;

  // Debounce the raw level and decide whether this channel issues a command
  always_comb begin
    last_raw_next      = last_raw;
    stable_level_next  = stable_level;
    last_active_next   = last_active;
    since_change_next  = since_change;
    override_mark_next = override_mark;
    req                = '0;
    act                = cfg.low_true ? !raw : raw;
    if (cfg.en) begin
      if (raw != last_raw) begin
        last_raw_next     = raw;
        since_change_next = '0;
      end else if (since_change != '1) begin
        since_change_next = since_change + DEB_W'(1);
      end
      if (raw != stable_level && since_change_next >= debounce_ticks) begin
        stable_level_next = raw;
        if (cfg.momentary) begin
          if (act && !last_active) begin
            req.offer = 1'b1;
            req.on    = !relay;
          end
        end else if (act != relay) begin
          req.offer = 1'b1;
          req.on    = act;
        end
        last_active_next = act;
        if (req.offer) begin
          override_mark_next = 1'b1;
        end
      end
    end
  end

  assign mark = override_mark_next;

  // Hold channel state between ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw      <= 1'b1;
      stable_level  <= 1'b1;
      last_active   <= 1'b0;
      since_change  <= '0;
      override_mark <= 1'b0;
    end else if (advance) begin
      last_raw      <= last_raw_next;
      stable_level  <= stable_level_next;
      last_active   <= last_active_next;
      since_change  <= since_change_next;
      override_mark <= override_mark_next;
    end
  end

endmodule

// ===== src/dsrc_queue.sv =====
module dsrc_queue
  import dsrc_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [SWCNT_W-1:0]    used,
  input  logic [INTERVAL_W-1:0] interval_ticks,
  input  remote_t               remote,
  input  logic [CHANNELS-1:0]   req_valid,
  input  logic [CHANNELS-1:0]   req_on,
  output apply_t                apply,
  output queue_status_t         status
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int RW = $clog2(CHANNELS + 1);
  localparam int SW = $clog2(3 * FIFO_DEPTH + CHANNELS + 1);

  entry_t                fifo [FIFO_DEPTH];
  logic [AW-1:0]         head, head_next;
  logic [CW-1:0]         count, count_next;
  logic [INTERVAL_W-1:0] interval_count, interval_next;

  logic                  rem_acc, rem_drop;
  logic [AW-1:0]         rem_addr;
  entry_t                rem_entry, head_entry;
  logic [CW-1:0]         c0, c1, space;
  logic [INTERVAL_W-1:0] ic_inc;
  logic                  serve, pop, hit;
  logic [RW-1:0]         rank [CHANNELS];
  logic [AW-1:0]         lane_addr [CHANNELS];
  logic [CHANNELS-1:0]   lane_acc;
  logic [CHANNELS-1:0]   lmask;
  logic [SW-1:0]         total_s, space_s, n_acc, drop_sum;
  logic [6:0]            level7;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    if (s >= SW'(FIFO_DEPTH)) begin
      return AW'(s - SW'(FIFO_DEPTH));
    end
    return AW'(s);
  endfunction

  // Queue the remote command, serve the head, then merge the lane requests
  always_comb begin
    rem_acc   = remote.valid && (count < CW'(FIFO_DEPTH));
    rem_drop  = remote.valid && !rem_acc;
    rem_addr  = wrap(SW'(head) + SW'(count));
    rem_entry = '{idx: IDX_W'(remote.index), on: remote.on};
    c0        = count + CW'(rem_acc);

    ic_inc        = (interval_count != '1) ? interval_count + INTERVAL_W'(1) : interval_count;
    serve         = ic_inc >= interval_ticks;
    interval_next = serve ? '0 : ic_inc;
    pop           = serve && (c0 != '0);

    // An empty queue can only serve the command queued this tick
    head_entry  = (count == '0) ? rem_entry : fifo[head];
    hit         = IDX_W'(used) > head_entry.idx;
    apply.valid = pop && hit;
    apply.idx   = head_entry.idx;
    apply.on    = head_entry.on;

    head_next = pop ? wrap(SW'(head) + SW'(1)) : head;
    c1        = c0 - CW'(pop);
    space     = CW'(FIFO_DEPTH) - c1;
    space_s   = SW'(space);

    // Rank each lane request among earlier lanes and place it behind the tail
    for (int i = 0; i < CHANNELS; i++) begin
      lmask        = (CHANNELS'(1) << i) - CHANNELS'(1);
      rank[i]      = RW'($countones(req_valid & lmask));
      lane_acc[i]  = req_valid[i] && (SW'(rank[i]) < space_s);
      lane_addr[i] = wrap(SW'(head_next) + SW'(c1) + SW'(rank[i]));
    end

    total_s    = SW'($countones(req_valid));
    n_acc      = (total_s < space_s) ? total_s : space_s;
    count_next = c1 + CW'(n_acc);
    drop_sum   = SW'(rem_drop) + total_s - n_acc;

    status.ignored = pop && !hit;
    status.dropped = (drop_sum > SW'(15)) ? '1 : DROP_W'(drop_sum);
    level7         = 7'(count_next);
    status.level   = level7[LEVEL_W-1:0];
  end

  // Advance queue pointers and the service timer
  always_ff @(posedge clk) begin
    if (rst) begin
      head           <= '0;
      count          <= '0;
      interval_count <= '0;
    end else if (advance) begin
      head           <= head_next;
      count          <= count_next;
      interval_count <= interval_next;
    end
  end

  // Write accepted commands into their slots
  always_ff @(posedge clk) begin
    if (advance) begin
      if (rem_acc) begin
        fifo[rem_addr] <= rem_entry;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        if (lane_acc[i]) begin
          fifo[lane_addr[i]] <= '{idx: IDX_W'(i), on: req_on[i]};
        end
      end
    end
  end

endmodule

// ===== src/debounced_switch_relay_controller.sv =====
// Debounced wall-switch and remote relay controller.
// Slave stream: one beat per 1 ms tick; tdata carries the raw switch levels
// and an optional remote command. Master stream: one result beat per tick
// with relay pin levels, override marks, service flags, drop count and the
// queue level. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_data); the user must write it only while the block is idle, which the block does not enforce.
// Timing: the result of a tick is registered in the output register when its
// beat is accepted, or in the skid entry while m_tready stalls it. Throughput:
// one tick per cycle while s_tready is high; all channel lanes and the command
// queue update are combinational between the input and the output register.
// Stall: the output register plus one skid entry hold results; s_tready
// stays high until both are full, so one more tick is taken while a result
// waits on m_tready.
// Reset (rst, synchronous): relays off, debounce state idle high, queue
// empty, timer zero, registers to their defaults, both output stages empty.
module debounced_switch_relay_controller
  import dsrc_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // raw_levels[7:0], remote_valid, remote_index[3:0], remote_on, zero pad
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // relay_drive[7:0], override_marks[7:0], applied, ignored, dropped[3:0],
  // queue_level[4:0], zero pad
  output logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [DEB_W-1:0]      debounce_ticks;
  logic [INTERVAL_W-1:0] command_interval_ticks;
  logic [SWCNT_W-1:0]    switch_count;
  logic [MASK_W-1:0]     manual_enable_mask;
  logic [MASK_W-1:0]     active_low_mask;
  logic [MASK_W-1:0]     momentary_mask;

  logic                  advance;
  logic [MASK_W-1:0]     raw_levels;
  remote_t               remote;
  logic [SWCNT_W-1:0]    used;
  apply_t                apply;
  queue_status_t         status;
  logic [CHANNELS-1:0]   relay_on, relay_after;
  logic [CHANNELS-1:0]   req_valid, req_on, mark;
  logic [MASK_W-1:0]     drive, marks;
  logic [OUT_W-1:0]      result;

  logic                  out_valid, skid_valid;
  logic [OUT_W-1:0]      out_data, skid_data;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks         <= DEBOUNCE_RST;
      command_interval_ticks <= INTERVAL_RST;
      switch_count           <= SWCNT_RST;
      manual_enable_mask     <= ENABLE_RST;
      active_low_mask        <= ACTLOW_RST;
      momentary_mask         <= MOMENT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:  debounce_ticks         <= cfg_data[DEB_W-1:0];
        REG_INTERVAL:  command_interval_ticks <= cfg_data[INTERVAL_W-1:0];
        REG_SWCOUNT:   switch_count           <= cfg_data[SWCNT_W-1:0];
        REG_ENABLE:    manual_enable_mask     <= cfg_data[MASK_W-1:0];
        REG_ACTLOW:    active_low_mask        <= cfg_data[MASK_W-1:0];
        REG_MOMENTARY: momentary_mask         <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input beat
  assign advance      = s_tvalid && s_tready;
  assign raw_levels   = s_tdata[IN_RAW_LSB +: MASK_W];
  assign remote.valid = s_tdata[IN_RVALID];
  assign remote.index = s_tdata[IN_RIDX_LSB +: REMOTE_IDX_W];
  assign remote.on    = s_tdata[IN_RON];
  assign used = (switch_count < CHANNELS) ? switch_count : SWCNT_W'(CHANNELS);

  dsrc_queue #(
    .CHANNELS   (CHANNELS),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .used           (used),
    .interval_ticks (command_interval_ticks),
    .remote         (remote),
    .req_valid      (req_valid),
    .req_on         (req_on),
    .apply          (apply),
    .status         (status)
  );

  // Apply the served command before the lanes look at the relays
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      relay_after[i] = (apply.valid && apply.idx == IDX_W'(i)) ? apply.on : relay_on[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_on <= '0;
    end else if (advance) begin
      relay_on <= relay_after;
    end
  end

  // One debounce lane per channel; only the first eight have wall inputs
  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    lane_cfg_t lcfg;
    lane_req_t lreq;
    logic      lraw;

    if (i < MASK_W) begin : g_wired
      assign lcfg.en        = manual_enable_mask[i] && (used > SWCNT_W'(i));
      assign lcfg.low_true  = active_low_mask[i];
      assign lcfg.momentary = momentary_mask[i];
      assign lraw           = raw_levels[i];
    end else begin : g_unwired
      assign lcfg = '0;
      assign lraw = 1'b0;
    end

    dsrc_lane u_lane (
      .clk            (clk),
      .rst            (rst),
      .advance        (advance),
      .cfg            (lcfg),
      .debounce_ticks (debounce_ticks),
      .raw            (lraw),
      .relay          (relay_after[i]),
      .req            (lreq),
      .mark           (mark[i])
    );

    assign req_valid[i] = lreq.offer;
    assign req_on[i]    = lreq.on;
  end

  // Relay pins are active low; channels that do not exist drive high
  for (genvar b = 0; b < MASK_W; b++) begin : g_pin
    if (b < CHANNELS) begin : g_used
      assign drive[b] = !relay_after[b];
      assign marks[b] = mark[b];
    end else begin : g_absent
      assign drive[b] = 1'b1;
      assign marks[b] = 1'b0;
    end
  end

  always_comb begin
    result = '0;
    result[OUT_DRIVE_LSB +: MASK_W]  = drive;
    result[OUT_MARK_LSB +: MASK_W]   = marks;
    result[OUT_APPLIED]              = apply.valid;
    result[OUT_IGNORED]              = status.ignored;
    result[OUT_DROP_LSB +: DROP_W]   = status.dropped;
    result[OUT_LEVEL_LSB +: LEVEL_W] = status.level;
  end

  // Output register with one skid entry
  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_tready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= advance;
        end
      end else if (advance) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (advance) begin
        out_data <= result;
      end
    end else if (advance) begin
      skid_data <= result;
    end
  end

endmodule

// ===== src/dsrc_checker.sv =====
module dsrc_checker
  import dsrc_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // A stalled result beat stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result payload changed while stalled");

  // The queue never reports more entries than its depth
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_LEVEL_LSB +: LEVEL_W] <= FIFO_DEPTH)
    else $error("queue level beyond depth");

  // A served command is either applied or ignored, never both
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[OUT_APPLIED] && m_tdata[OUT_IGNORED]))
    else $error("command both applied and ignored");

  // Reset empties both output stages
  assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output stages not empty after reset");

endmodule

bind debounced_switch_relay_controller dsrc_checker #(
  .FIFO_DEPTH (FIFO_DEPTH)
) u_dsrc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dsrc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 4;
  localparam bit TYPED       = 1'b1;
  localparam bit PREDICTED   = 1'b0;
  localparam int SCRIPT_ROWS = 22;

  // One result beat, fields from the lowest bit up reversed into MSB-first order
  typedef struct packed {
    logic [MASK_W-1:0]  drive;
    logic [MASK_W-1:0]  marks;
    logic               applied;
    logic               ignored;
    logic [DROP_W-1:0]  dropped;
    logic [LEVEL_W-1:0] level;
  } tick_status_t;

  // One row of the directed script
  typedef struct packed {
    logic [7:0]              raw;
    logic                    remote;
    logic [REMOTE_IDX_W-1:0] ridx;
    logic                    ron;
    logic                    typed;
    tick_status_t            status;
  } script_row_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PULSE, RX_STALL} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Register shadows
  logic [DEB_W-1:0]      cfg_debounce = DEBOUNCE_RST;
  logic [INTERVAL_W-1:0] cfg_interval = INTERVAL_RST;
  logic [SWCNT_W-1:0]    cfg_swcount  = SWCNT_RST;
  logic [MASK_W-1:0]     cfg_enable   = ENABLE_RST;
  logic [MASK_W-1:0]     cfg_actlow   = ACTLOW_RST;
  logic [MASK_W-1:0]     cfg_moment   = MOMENT_RST;

  // Controller state as the block should hold it
  logic [7:0] relay_q;
  logic [7:0] raw_last;
  logic [7:0] level_stable;
  logic [7:0] act_last;
  logic [7:0] mark_q;
  logic [7:0] settle_cnt [8];
  logic [5:0] relay_cmds [$];
  int         interval_cnt;

  tick_status_t status_due [$];
  script_row_t  script [SCRIPT_ROWS];
  int           mismatches = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  int           rx_tick = 0;
  rx_mode_t     rx_mode = RX_OPEN;
  tick_status_t got_status;
  tick_status_t want_status;

  debounced_switch_relay_controller DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Push a command into the relay queue; refuse it when the queue is full
  function automatic bit queue_cmd(logic [IDX_W-1:0] idx, logic on);
    if (relay_cmds.size() >= FIFO_DEPTH_DEF) return 1'b0;
    relay_cmds.insert(relay_cmds.size(), {idx, on});
    return 1'b1;
  endfunction

  // Advance the controller by one tick and return the status it reports
  function automatic tick_status_t run_tick(logic [7:0] raw, logic remote,
                                            logic [REMOTE_IDX_W-1:0] ridx, logic ron);
    tick_status_t st;
    int           used;
    int           drops;
    int           ch;
    logic [5:0]   cmd;
    logic         r;
    logic         act;
    st = '0;
    drops = 0;
    used = (cfg_swcount < CHANNELS_DEF) ? int'(cfg_swcount) : CHANNELS_DEF;
    // queue the remote command first
    if (remote) begin
      if (!queue_cmd({1'b0, ridx}, ron)) drops++;
    end
    // serve one queued command once the interval has run out
    if (interval_cnt < 1023) interval_cnt++;
    if (interval_cnt >= cfg_interval) begin
      interval_cnt = 0;
      if (relay_cmds.size() > 0) begin
        cmd = relay_cmds.pop_front();
        if (cmd[5:1] < used) begin
          relay_q[cmd[3:1]] = cmd[0];
          st.applied = 1'b1;
        end else begin
          st.ignored = 1'b1;
        end
      end
    end
    // debounce each enabled lane in use, then map it onto a relay command
    for (ch = 0; ch < CHANNELS_DEF; ch++) begin
      if (ch < used && cfg_enable[ch]) begin
        r = raw[ch];
        if (r != raw_last[ch]) begin
          raw_last[ch] = r;
          settle_cnt[ch] = '0;
        end else if (settle_cnt[ch] != 8'hFF) begin
          settle_cnt[ch] = settle_cnt[ch] + 8'd1;
        end
        if (r != level_stable[ch] && settle_cnt[ch] >= cfg_debounce) begin
          level_stable[ch] = r;
          act = cfg_actlow[ch] ? ~r : r;
          if (cfg_moment[ch]) begin
            if (act && !act_last[ch]) begin
              if (!queue_cmd(IDX_W'(ch), ~relay_q[ch])) drops++;
              mark_q[ch] = 1'b1;
            end
          end else if (act != relay_q[ch]) begin
            if (!queue_cmd(IDX_W'(ch), act)) drops++;
            mark_q[ch] = 1'b1;
          end
          act_last[ch] = act;
        end
      end
    end
    st.drive   = ~relay_q;
    st.marks   = mark_q;
    st.dropped = DROP_W'(drops);
    st.level   = LEVEL_W'(relay_cmds.size());
    return st;
  endfunction

  // Status right after reset with no switch activity yet
  function automatic tick_status_t reset_status(int drops, int level);
    return {8'hFF, 8'h00, 1'b0, 1'b0, DROP_W'(drops), LEVEL_W'(level)};
  endfunction

  // Offer one tick beat in bursts with random gaps; record its status on accept
  task automatic send_tick(logic [7:0] raw, logic remote, logic [REMOTE_IDX_W-1:0] ridx,
                           logic ron, logic typed, tick_status_t typed_status);
    logic [IN_W-1:0] beat;
    tick_status_t    st;
    int              gap;
    beat = '0;
    beat[IN_RAW_LSB +: 8] = raw;
    beat[IN_RVALID] = remote;
    beat[IN_RIDX_LSB +: REMOTE_IDX_W] = ridx;
    beat[IN_RON] = ron;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    do @(posedge clk); while (!s_tready);
    st = run_tick(raw, remote, ridx, ron);
    status_due.insert(status_due.size(), typed ? typed_status : st);
    burst_left--;
  endtask

  // Drop valid and hold until every status has come back
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
  endtask

  // Write one register; bits above the register width carry junk
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
    logic [CFG_W-1:0] junk;
    logic [CFG_W-1:0] data;
    junk = CFG_W'($urandom);
    case (idx)
      REG_DEBOUNCE: begin
        data = {junk[CFG_W-1:DEB_W], value[DEB_W-1:0]};
        cfg_debounce = value[DEB_W-1:0];
      end
      REG_INTERVAL: begin
        data = value;
        cfg_interval = value;
      end
      REG_SWCOUNT: begin
        data = {junk[CFG_W-1:SWCNT_W], value[SWCNT_W-1:0]};
        cfg_swcount = value[SWCNT_W-1:0];
      end
      REG_ENABLE: begin
        data = {junk[CFG_W-1:MASK_W], value[MASK_W-1:0]};
        cfg_enable = value[MASK_W-1:0];
      end
      REG_ACTLOW: begin
        data = {junk[CFG_W-1:MASK_W], value[MASK_W-1:0]};
        cfg_actlow = value[MASK_W-1:0];
      end
      default: begin
        data = {junk[CFG_W-1:MASK_W], value[MASK_W-1:0]};
        cfg_moment = value[MASK_W-1:0];
      end
    endcase
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  // Reconfigure while drained, then run random ticks: held switch levels with
  // occasional single-bit changes, one-tick glitches and remote commands
  task automatic run_phase(logic [7:0] deb, logic [9:0] intv, logic [3:0] swc,
                           logic [7:0] en, logic [7:0] al, logic [7:0] mom,
                           int items, int chg_pct, int rem_pct);
    logic [7:0] raw_cur;
    logic [7:0] raw_out;
    int         roll;
    int         bit_sel;
    wait_drained();
    write_reg(REG_DEBOUNCE, CFG_W'(deb));
    write_reg(REG_INTERVAL, intv);
    write_reg(REG_SWCOUNT, CFG_W'(swc));
    write_reg(REG_ENABLE, CFG_W'(en));
    write_reg(REG_ACTLOW, CFG_W'(al));
    write_reg(REG_MOMENTARY, CFG_W'(mom));
    @(negedge clk);
    cfg_we <= 1'b0;
    raw_cur = 8'($urandom);
    repeat (items) begin
      roll = $urandom_range(0, 99);
      raw_out = raw_cur;
      if (roll < chg_pct) begin
        bit_sel = $urandom_range(0, 7);
        raw_cur[bit_sel] = ~raw_cur[bit_sel];
        raw_out = raw_cur;
      end else if (roll < chg_pct + chg_pct / 4) begin
        raw_out = raw_cur ^ 8'($urandom);
      end
      send_tick(raw_out, $urandom_range(0, 99) < rem_pct, REMOTE_IDX_W'($urandom),
                1'($urandom), PREDICTED, '0);
    end
  endtask

  // Receiver: switch between open, random, pulsed and stalled ready patterns
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 50 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
      RX_PULSE:  m_tready <= ((rx_tick % 5) < 2);
      default:   m_tready <= ((rx_tick % 16) >= 10);
    endcase
  end

  // Compare each result beat with the oldest recorded status
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_status.drive   = m_tdata[OUT_DRIVE_LSB +: MASK_W];
      got_status.marks   = m_tdata[OUT_MARK_LSB +: MASK_W];
      got_status.applied = m_tdata[OUT_APPLIED];
      got_status.ignored = m_tdata[OUT_IGNORED];
      got_status.dropped = m_tdata[OUT_DROP_LSB +: DROP_W];
      got_status.level   = m_tdata[OUT_LEVEL_LSB +: LEVEL_W];
      if (status_due.size() == 0) begin
        if (mismatches < 10) $display("unexpected result beat %h", m_tdata);
        mismatches++;
      end else begin
        want_status = status_due.pop_front();
        if (got_status.drive !== want_status.drive || got_status.marks !== want_status.marks
            || got_status.applied !== want_status.applied
            || got_status.ignored !== want_status.ignored
            || got_status.dropped !== want_status.dropped
            || got_status.level !== want_status.level) begin
          if (mismatches < 10) begin
            $display("mismatch exp: drive=%h marks=%h applied=%b ignored=%b drop=%0d lvl=%0d",
                     want_status.drive, want_status.marks, want_status.applied,
                     want_status.ignored, want_status.dropped, want_status.level);
            $display("         got: drive=%h marks=%h applied=%b ignored=%b drop=%0d lvl=%0d",
                     got_status.drive, got_status.marks, got_status.applied,
                     got_status.ignored, got_status.dropped, got_status.level);
          end
          mismatches++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // Controller state after reset
    relay_q = '0;
    raw_last = '1;
    level_stable = '1;
    act_last = '0;
    mark_q = '0;
    for (int i = 0; i < 8; i++) settle_cnt[i] = '0;
    relay_cmds.delete();
    interval_cnt = 0;

    // Default settings: fill the queue with remote commands of every index
    // extreme, then overflow it; nothing settles or gets served this early
    script[0]  = {8'hFF, 1'b0, 4'h0, 1'b0, TYPED, reset_status(0, 0)};
    script[1]  = {8'h00, 1'b1, 4'h0, 1'b1, TYPED, reset_status(0, 1)};
    script[2]  = {8'hFF, 1'b1, 4'hF, 1'b0, TYPED, reset_status(0, 2)};
    script[3]  = {8'h55, 1'b1, 4'h7, 1'b1, TYPED, reset_status(0, 3)};
    script[4]  = {8'hAA, 1'b1, 4'h8, 1'b0, TYPED, reset_status(0, 4)};
    script[5]  = {8'h0F, 1'b1, 4'h1, 1'b1, TYPED, reset_status(0, 5)};
    script[6]  = {8'hF0, 1'b1, 4'h2, 1'b0, TYPED, reset_status(0, 6)};
    script[7]  = {8'h33, 1'b1, 4'h3, 1'b1, TYPED, reset_status(0, 7)};
    script[8]  = {8'hCC, 1'b1, 4'h4, 1'b0, TYPED, reset_status(0, 8)};
    script[9]  = {8'h01, 1'b1, 4'h5, 1'b1, TYPED, reset_status(0, 9)};
    script[10] = {8'h80, 1'b1, 4'h6, 1'b0, TYPED, reset_status(0, 10)};
    script[11] = {8'h7E, 1'b1, 4'h9, 1'b1, TYPED, reset_status(0, 11)};
    script[12] = {8'h81, 1'b1, 4'hA, 1'b0, TYPED, reset_status(0, 12)};
    script[13] = {8'hFE, 1'b1, 4'hB, 1'b1, TYPED, reset_status(0, 13)};
    script[14] = {8'h7F, 1'b1, 4'hC, 1'b0, TYPED, reset_status(0, 14)};
    script[15] = {8'h3C, 1'b1, 4'hD, 1'b1, TYPED, reset_status(0, 15)};
    script[16] = {8'hC3, 1'b1, 4'hE, 1'b0, TYPED, reset_status(0, 16)};
    // queue full: the remote command is dropped
    script[17] = {8'h00, 1'b1, 4'h2, 1'b1, TYPED, reset_status(1, 16)};
    script[18] = {8'h00, 1'b0, 4'h0, 1'b0, TYPED, reset_status(0, 16)};
    script[19] = {8'hFF, 1'b1, 4'hF, 1'b1, TYPED, reset_status(1, 16)};
    script[20] = {8'h00, 1'b1, 4'h3, 1'b0, PREDICTED, 27'd0};
    script[21] = {8'h00, 1'b0, 4'h0, 1'b0, PREDICTED, 27'd0};

    // Hold reset, then release it at a falling clock edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed script
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      send_tick(script[i].raw, script[i].remote, script[i].ridx, script[i].ron,
                script[i].typed, script[i].status);
    end

    // Serve every tick with instant debounce: drain the queue, maintained lanes
    run_phase(8'd0, 10'd0, 4'd8, 8'hFF, 8'h00, 8'h00, 60, 30, 30);
    // All momentary, count beyond the channel total
    run_phase(8'd2, 10'd3, 4'd15, 8'hFF, 8'h0F, 8'hFF, 60, 15, 20);
    // Longest debounce and interval: levels held long enough to saturate
    run_phase(8'd255, 10'd1023, 4'd8, 8'hFF, 8'hFF, 8'h55, 270, 0, 10);
    // No channels in use: every served command is ignored
    run_phase(8'd1, 10'd1, 4'd0, 8'($urandom), 8'($urandom), 8'($urandom), 40, 30, 40);
    // Random settings
    repeat (3) begin
      run_phase(8'($urandom_range(0, 5)), 10'($urandom_range(0, 8)),
                4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom), 8'($urandom),
                40, 20, 30);
    end
    // Slow service with busy switches: overflow and multi-drop ticks
    run_phase(8'd0, 10'd20, 4'd8, 8'hFF, 8'($urandom), 8'($urandom), 60, 40, 60);
    // Wall switches disabled: debounce state frozen
    run_phase(8'd0, 10'd2, 4'd8, 8'h00, 8'hAA, 8'hF0, 30, 30, 30);
    // Re-enable and let the frozen lanes catch up
    run_phase(8'd0, 10'd0, 4'd8, 8'hFF, 8'h00, 8'h0F, 40, 20, 20);

    // Drain and let the output stages settle
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dsrc_pkg.sv
src/dsrc_lane.sv
src/dsrc_queue.sv
src/debounced_switch_relay_controller.sv
src/dsrc_checker.sv
tb/testbench.sv
